FILE: hdl/kcs_pkg.sv
// Shared types and constants of the Kuwahara colour smoothing block.
`default_nettype none
package kcs_pkg;

  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int ENTRY_W    = 2 * PIX_W;
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 10;
  localparam int SUM4_W     = CH_W + 2;
  localparam int SUM9_W     = 12;
  localparam int DIFF_W     = 12;
  localparam int SQ_W       = 2 * DIFF_W;
  // largest measure is 3 * 2295^2, below 2^24
  localparam int MEASURE_W  = 24;

  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int WIDTH_RESET  = 380;
  localparam int HEIGHT_RESET = 500;
  localparam int ROW_LIMIT    = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [1:0] QUAD_UL = 2'd0;
  localparam logic [1:0] QUAD_UR = 2'd1;
  localparam logic [1:0] QUAD_LL = 2'd2;
  localparam logic [1:0] QUAD_LR = 2'd3;

  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = 4;
  localparam int OUT_CNT_W = 5;

  // channel 0 (a) in the low byte
  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;
  typedef logic [3:0][NUM_CH-1:0][CH_W-1:0] quad_mean_t;
  typedef logic [NUM_CH-1:0][SUM9_W-1:0] win_sum_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } tag_t;

  // packed so that smooth a sits in the low bits
  typedef struct packed {
    logic [1:0]           quad;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    pix_t                 smooth;
  } result_t;

  typedef struct packed {
    logic    last;
    result_t data;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hdl/kcs_line_store.sv
// Two-row line store: one read and one write per cycle, registered read data.
`default_nettype none
module kcs_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [kcs_pkg::ENTRY_W-1:0]    rd_data,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [kcs_pkg::ENTRY_W-1:0]    wr_data
);
  import kcs_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kcs_window.sv
// Column window of the 3x3 neighborhood plus window sums and quadrant means.
`default_nettype none
module kcs_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  kcs_pkg::tag_t       in_tag,
  input  kcs_pkg::pix_t       top,
  input  kcs_pkg::pix_t       mid,
  input  kcs_pkg::pix_t       px,
  output kcs_pkg::tag_t       out_tag,
  output kcs_pkg::quad_mean_t means,
  output kcs_pkg::win_sum_t   wsum
);
  import kcs_pkg::*;

  // entries 0..2: column col-2, rows r-2..r; entries 3..5: column col-1
  pix_t               col_win [6];
  pix_t               g [3][3];
  logic [SUM4_W-1:0]  sum4 [4][NUM_CH];
  quad_mean_t         means_next;
  win_sum_t           wsum_next;

  always_comb begin
    g[0][0] = col_win[0];
    g[1][0] = col_win[1];
    g[2][0] = col_win[2];
    g[0][1] = col_win[3];
    g[1][1] = col_win[4];
    g[2][1] = col_win[5];
    g[0][2] = top;
    g[1][2] = mid;
    g[2][2] = px;
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      wsum_next[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          wsum_next[ch] = wsum_next[ch] + SUM9_W'(g[r][c][ch]);
        end
      end
      for (int q = 0; q < 4; q++) begin
        sum4[q][ch] = SUM4_W'(g[q >> 1][q & 1][ch])
                    + SUM4_W'(g[q >> 1][(q & 1) + 1][ch])
                    + SUM4_W'(g[(q >> 1) + 1][q & 1][ch])
                    + SUM4_W'(g[(q >> 1) + 1][(q & 1) + 1][ch]);
        means_next[q][ch] = sum4[q][ch][SUM4_W-1:2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else begin
      out_tag <= in_tag;
      means   <= means_next;
      wsum    <= wsum_next;
      if (step) begin
        col_win[0] <= col_win[3];
        col_win[1] <= col_win[4];
        col_win[2] <= col_win[5];
        col_win[3] <= top;
        col_win[4] <= mid;
        col_win[5] <= px;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kcs_select.sv
// Quadrant measures, minimum search and result register.
`default_nettype none
module kcs_select (
  input  logic                clk,
  input  logic                rst,
  input  kcs_pkg::tag_t       in_tag,
  input  kcs_pkg::quad_mean_t means,
  input  kcs_pkg::win_sum_t   wsum,
  output logic                out_valid,
  output kcs_pkg::out_item_t  out_item
);
  import kcs_pkg::*;

  typedef logic [3:0][NUM_CH-1:0][DIFF_W-1:0] diff_t;
  typedef logic [3:0][NUM_CH-1:0][SQ_W-1:0]   sq_t;
  typedef logic [3:0][MEASURE_W-1:0]          meas_t;

  diff_t                diff_next;
  logic [DIFF_W-1:0]    nine;

  tag_t                 t1_tag, t2_tag, t3_tag, t4_tag;
  quad_mean_t           t1_means, t2_means, t3_means, t4_means;
  diff_t                t1_diff;
  sq_t                  t2_sq;
  meas_t                t3_meas;
  logic [1:0]           t4_q_lo, t4_q_hi;
  logic [MEASURE_W-1:0] t4_m_lo, t4_m_hi;
  logic [1:0]           best;

  // |9 * mean - window sum| per quadrant and channel
  always_comb begin
    nine = '0;
    for (int q = 0; q < 4; q++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        nine = DIFF_W'({means[q][ch], 3'b000}) + DIFF_W'(means[q][ch]);
        diff_next[q][ch] = (nine >= wsum[ch]) ? nine - wsum[ch] : wsum[ch] - nine;
      end
    end
  end

  // keep the earlier quadrant on ties
  assign best = (t4_m_hi < t4_m_lo) ? t4_q_hi : t4_q_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_tag.valid <= 1'b0;
      t2_tag.valid <= 1'b0;
      t3_tag.valid <= 1'b0;
      t4_tag.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      t1_tag   <= in_tag;
      t1_means <= means;
      t1_diff  <= diff_next;

      t2_tag   <= t1_tag;
      t2_means <= t1_means;
      for (int q = 0; q < 4; q++) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          t2_sq[q][ch] <= SQ_W'(t1_diff[q][ch]) * SQ_W'(t1_diff[q][ch]);
        end
      end

      t3_tag   <= t2_tag;
      t3_means <= t2_means;
      for (int q = 0; q < 4; q++) begin
        t3_meas[q] <= MEASURE_W'(t2_sq[q][0] + t2_sq[q][1] + t2_sq[q][2]);
      end

      t4_tag   <= t3_tag;
      t4_means <= t3_means;
      if (t3_meas[1] < t3_meas[0]) begin
        t4_q_lo <= QUAD_UR;
        t4_m_lo <= t3_meas[1];
      end else begin
        t4_q_lo <= QUAD_UL;
        t4_m_lo <= t3_meas[0];
      end
      if (t3_meas[3] < t3_meas[2]) begin
        t4_q_hi <= QUAD_LR;
        t4_m_hi <= t3_meas[3];
      end else begin
        t4_q_hi <= QUAD_LL;
        t4_m_hi <= t3_meas[2];
      end

      out_valid            <= t4_tag.valid;
      out_item.last        <= t4_tag.last;
      out_item.data.quad   <= best;
      out_item.data.row    <= t4_tag.row;
      out_item.data.col    <= t4_tag.col;
      out_item.data.smooth <= t4_means[best];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kcs_out_fifo.sv
// Result queue that decouples the pipeline from the output handshake.
`default_nettype none
module kcs_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  kcs_pkg::out_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output kcs_pkg::out_item_t out_item
);
  import kcs_pkg::*;

  out_item_t              entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;
  logic [OUT_CNT_W-1:0]   count;
  logic                   pop;

  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  // upstream holds a credit per queued result, so a push never overflows
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_valid) begin
        entries[wr_ptr] <= in_item;
        wr_ptr          <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(in_valid) - OUT_CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/kuwahara_colour_smoothing.sv
// Results pass s1, the window register, t1, t2, t3, t4, the result register and the queue.
// Throughput: one pixel per clock; the line store does one read and one write per cycle.
// Input stalls only in reset or when all 16 result slots (pipeline, queue) are claimed.
// Reset clears the row and column counters and loads 380 x 500; line store contents
// need no clearing since rows 0 and 1 of a frame refill it before any result.
`default_nettype none
module kuwahara_colour_smoothing #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // chan_a, chan_b, chan_c
  input  logic                              s_tuser,   // frame_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // smooth_a, smooth_b, smooth_c, centre_row, centre_col, chosen_quadrant
  output logic [47:0]                       m_tdata,
  output logic                              m_tlast,   // last_pixel
  input  logic                              cfg_wr_en,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kcs_pkg::*;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WidthReset = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  // configuration, held as last index
  logic [COL_W-1:0]        w_m1;
  logic [ROW_W-1:0]        h_m1;
  logic [WIDTH_CFG_W-1:0]  cfg_w;
  logic [HEIGHT_CFG_W-1:0] cfg_h;

  logic [ROW_W-1:0]        row_count;
  logic [COL_W-1:0]        col_count;
  logic [OUT_CNT_W-1:0]    pending;

  logic                    accept;
  logic [ROW_W-1:0]        row0;
  logic [COL_W-1:0]        col0;
  logic [COL_W-1:0]        col_m1;
  logic                    emit0;
  logic                    last0;

  logic                    s1_valid;
  pix_t                    s1_px;
  logic [COL_W-1:0]        s1_col;
  tag_t                    s1_tag;

  logic                    s2w_valid;
  logic [COL_W-1:0]        s2w_addr;
  logic [ENTRY_W-1:0]      s2w_data;

  logic [ENTRY_W-1:0]      rd_data;
  logic [ENTRY_W-1:0]      entry;
  logic [ENTRY_W-1:0]      wr_data;
  pix_t                    top;
  pix_t                    mid;
  tag_t                    win_tag_in;

  tag_t                    win_tag;
  quad_mean_t              win_means;
  win_sum_t                win_sum;
  logic                    res_valid;
  out_item_t               res_item;
  out_item_t               fifo_item;

  assign cfg_w = cfg_data[WIDTH_CFG_W-1:0];
  assign cfg_h = cfg_data[HEIGHT_CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1 <= COL_W'(WidthReset - 1);
      h_m1 <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_w == '0) begin
            w_m1 <= '0;
          end else if (32'(cfg_w) > MAX_WIDTH) begin
            w_m1 <= COL_W'(MAX_WIDTH - 1);
          end else begin
            w_m1 <= COL_W'(cfg_w - WIDTH_CFG_W'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_h == '0) begin
            h_m1 <= '0;
          end else if (32'(cfg_h) > ROW_LIMIT) begin
            h_m1 <= ROW_W'(ROW_LIMIT - 1);
          end else begin
            h_m1 <= ROW_W'(cfg_h - HEIGHT_CFG_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // position of the incoming pixel; frame_start forces the origin
  assign s_tready = !rst && (pending < OUT_CNT_W'(OUT_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign row0     = s_tuser ? '0 : row_count;
  assign col0     = s_tuser ? '0 : col_count;
  assign col_m1   = col0 - COL_W'(1);
  assign emit0    = (row0 >= ROW_W'(2)) && (col0 >= COL_W'(2)) &&
                    (row0 <= h_m1) && (col0 <= w_m1);
  assign last0    = (row0 == h_m1) && (col0 == w_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      pending   <= '0;
      s1_valid  <= 1'b0;
      s2w_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (col0 >= w_m1) begin
          col_count <= '0;
          row_count <= (row0 >= h_m1) ? '0 : row0 + ROW_W'(1);
        end else begin
          col_count <= col0 + COL_W'(1);
          row_count <= row0;
        end
      end
      pending <= pending + OUT_CNT_W'(accept && emit0) - OUT_CNT_W'(m_tvalid && m_tready);

      s1_valid      <= accept;
      s1_px         <= s_tdata;
      s1_col        <= col0;
      s1_tag.valid  <= emit0;
      s1_tag.last   <= last0;
      s1_tag.row    <= row0 - ROW_W'(1);
      s1_tag.col    <= COL_OUT_W'(col_m1);

      s2w_valid <= s1_valid;
      s2w_addr  <= s1_col;
      s2w_data  <= wr_data;
    end
  end

  // take the entry of the last write, held in s2w, when the read raced that write
  assign entry   = (s2w_valid && (s2w_addr == s1_col)) ? s2w_data : rd_data;
  assign mid     = entry[PIX_W-1:0];
  assign top     = entry[ENTRY_W-1:PIX_W];
  assign wr_data = {mid, s1_px};

  always_comb begin
    win_tag_in       = s1_tag;
    win_tag_in.valid = s1_valid && s1_tag.valid;
  end

  kcs_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col0),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  kcs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_valid),
    .in_tag  (win_tag_in),
    .top     (top),
    .mid     (mid),
    .px      (s1_px),
    .out_tag (win_tag),
    .means   (win_means),
    .wsum    (win_sum)
  );

  kcs_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (win_tag),
    .means     (win_means),
    .wsum      (win_sum),
    .out_valid (res_valid),
    .out_item  (res_item)
  );

  kcs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_item   (res_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (fifo_item)
  );

  assign m_tdata = fifo_item.data;
  assign m_tlast = fifo_item.last;

endmodule
`default_nettype wire
